FILE: rtl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants, types and helpers for the banked memory mapper.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // Sizes
  localparam int RAM_BYTES   = 8192;
  localparam int RAM_AW      = $clog2(RAM_BYTES);
  localparam int PAGE_BYTES  = 16384;
  localparam int PAGE_AW     = $clog2(PAGE_BYTES);
  localparam int FIXED_BYTES = 1024;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int ROM_AW      = 22;

  // Address map
  localparam logic [ADDR_W-1:0] WIN1_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] WIN2_BASE = 16'h8000;
  localparam logic [ADDR_W-1:0] RAM_BASE  = 16'hC000;
  localparam logic [ADDR_W-1:0] REG_SLOT0 = 16'hFFFD;
  localparam logic [ADDR_W-1:0] REG_SLOT1 = 16'hFFFE;
  localparam logic [ADDR_W-1:0] REG_SLOT2 = 16'hFFFF;
  localparam logic [ADDR_W:0]   FIXED_END = (ADDR_W+1)'(FIXED_BYTES);

  // Page masking
  localparam logic [DATA_W-1:0] PAGE_HI_MASK   = 8'hF0;
  localparam logic [DATA_W-1:0] PAGE_LO_MASK   = 8'h0F;
  localparam logic [DATA_W-1:0] ROM_BLOCKS_RST = 8'd32;
  localparam logic [DATA_W-1:0] SLOT0_RST      = 8'd0;
  localparam logic [DATA_W-1:0] SLOT1_RST      = 8'd1;
  localparam logic [DATA_W-1:0] SLOT2_RST      = 8'd2;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Decoded access, passed from the page unit to the top level
  typedef struct packed {
    logic              ram_wr;
    logic              ram_rd;
    logic              rom_fetch;
    logic [ROM_AW-1:0] rom_address;
    logic [DATA_W-1:0] wdata;
  } bmm_dec_t;

  // Mask a page value with the ROM block count; small ROMs use a bare mask on slot 2
  function automatic logic [DATA_W-1:0] page_mask(
    input logic [DATA_W-1:0] v,
    input logic              third,
    input logic [DATA_W-1:0] blocks
  );
    logic [DATA_W-1:0] m;
    if (third && (blocks <= PAGE_LO_MASK)) begin
      m = blocks;
    end else begin
      m = (blocks & PAGE_HI_MASK) | PAGE_LO_MASK;
    end
    return v & m;
  endfunction

  // Physical ROM address: page times page size plus window offset
  function automatic logic [ROM_AW-1:0] rom_addr(
    input logic [DATA_W-1:0]  page,
    input logic [PAGE_AW-1:0] offset
  );
    return (ROM_AW'(page) << PAGE_AW) | ROM_AW'(offset);
  endfunction

endpackage

FILE: rtl/bmm_in_if.sv
// ----------------------------------------------------------------------------
// bmm_in_if
// Bus access channel: operation, address and write byte.
// ----------------------------------------------------------------------------
interface bmm_in_if
  import bmm_pkg::*;
;
  logic              valid;
  logic              ready;
  op_t               op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output op, output address, output write_data,
                  input ready);
  modport sink   (input valid, input op, input address, input write_data,
                  output ready);
endinterface

FILE: rtl/bmm_out_if.sv
// ----------------------------------------------------------------------------
// bmm_out_if
// Result channel: RAM byte, ROM fetch flag and ROM address.
// ----------------------------------------------------------------------------
interface bmm_out_if
  import bmm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              rom_fetch;
  logic [ROM_AW-1:0] rom_address;

  modport source (output valid, output read_data, output rom_fetch,
                  output rom_address, input ready);
  modport sink   (input valid, input read_data, input rom_fetch,
                  input rom_address, output ready);
endinterface

FILE: rtl/bmm_cfg_if.sv
// ----------------------------------------------------------------------------
// bmm_cfg_if
// Configuration write channel carrying the ROM block count.
// ----------------------------------------------------------------------------
interface bmm_cfg_if
  import bmm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rom_blocks;

  modport source (output valid, output rom_blocks, input ready);
  modport sink   (input valid, input rom_blocks, output ready);
endinterface

FILE: rtl/bmm_ram.sv
// ----------------------------------------------------------------------------
// bmm_ram
// Work RAM, one write and one registered read port, zeroed by a sweep
// after reset.
// ----------------------------------------------------------------------------
module bmm_ram
  import bmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [RAM_AW-1:0] wr_idx,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [RAM_AW-1:0] rd_idx,
  output logic [DATA_W-1:0] rd_data,
  output logic              busy
);

  logic [DATA_W-1:0] mem [RAM_BYTES];
  logic              clearing_r;
  logic [RAM_AW-1:0] clr_idx_r;
  logic              we;
  logic [RAM_AW-1:0] we_idx;
  logic [DATA_W-1:0] we_data;
  logic [DATA_W-1:0] rd_data_r;

  // Advance the clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == RAM_AW'(RAM_BYTES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Sweep owns the write port while it runs
  always_comb begin
    we      = clearing_r | wr_en;
    we_idx  = clearing_r ? clr_idx_r : wr_idx;
    we_data = clearing_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[we_idx] <= we_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

FILE: rtl/bmm_pages.sv
// ----------------------------------------------------------------------------
// bmm_pages
// Page registers, ROM block count and address decode.
// ----------------------------------------------------------------------------
module bmm_pages
  import bmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              acc_en,
  input  op_t               op,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output bmm_dec_t          dec
);

  logic [DATA_W-1:0] rom_blocks_r;
  logic [DATA_W-1:0] slot0_r, slot1_r, slot2_r;
  logic [DATA_W-1:0] mask_lo;
  logic [DATA_W-1:0] mask_hi;

  always_comb begin
    mask_lo = page_mask(write_data, 1'b0, rom_blocks_r);
    mask_hi = page_mask(write_data, 1'b1, rom_blocks_r);
  end

  // Decode the access
  always_comb begin
    dec = '0;
    dec.wdata = write_data;
    if (op == OP_WRITE) begin
      dec.ram_wr = (address >= RAM_BASE);
      unique case (address)
        REG_SLOT0, REG_SLOT1: dec.wdata = mask_lo;
        REG_SLOT2:            dec.wdata = mask_hi;
        default:              dec.wdata = write_data;
      endcase
    end else if (address < WIN1_BASE) begin
      dec.rom_fetch = 1'b1;
      if ({1'b0, address} < FIXED_END) begin
        dec.rom_address = ROM_AW'(address);
      end else begin
        dec.rom_address = rom_addr(slot0_r, address[PAGE_AW-1:0]);
      end
    end else if (address < WIN2_BASE) begin
      dec.rom_fetch   = 1'b1;
      dec.rom_address = rom_addr(slot1_r, address[PAGE_AW-1:0]);
    end else if (address < RAM_BASE) begin
      dec.rom_fetch   = 1'b1;
      dec.rom_address = rom_addr(slot2_r, address[PAGE_AW-1:0]);
    end else begin
      dec.ram_rd = 1'b1;
    end
  end

  // Update the ROM block count on a configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_blocks_r <= ROM_BLOCKS_RST;
    end else if (cfg_we) begin
      rom_blocks_r <= cfg_data;
    end
  end

  // Load page registers on control register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot0_r <= SLOT0_RST;
      slot1_r <= SLOT1_RST;
      slot2_r <= SLOT2_RST;
    end else if (acc_en && (op == OP_WRITE)) begin
      if (address == REG_SLOT0) begin
        slot0_r <= mask_lo;
      end
      if (address == REG_SLOT1) begin
        slot1_r <= mask_lo;
      end
      if (address == REG_SLOT2) begin
        slot2_r <= mask_hi;
      end
    end
  end

endmodule

FILE: rtl/banked_memory_mapper.sv
// ----------------------------------------------------------------------------
// banked_memory_mapper
// Bus access mapper with paged ROM windows and mirrored work RAM.
// ----------------------------------------------------------------------------
// One bus transaction is taken per clock while the RAM sweep is done and no
// result is held off; its result is presented on the cycle after acceptance
// and is held in an output register, so a new transaction is taken in the
// same cycle the previous result is consumed. After reset the work RAM is
// zeroed by a sweep over all RAM_BYTES (8192) entries during which no bus
// transaction is accepted; configuration writes are taken at any time and
// must only be issued while the mapper is idle.
module banked_memory_mapper
  import bmm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  bmm_in_if.sink       in_bus,
  bmm_out_if.source    out_bus,
  bmm_cfg_if.sink      cfg_bus
);

  bmm_dec_t          dec;
  logic              acc;
  logic              ram_busy;
  logic [DATA_W-1:0] ram_q;

  logic              out_valid_r, out_valid_nxt;
  logic              ram_sel_r;
  logic              rom_fetch_r;
  logic [ROM_AW-1:0] rom_address_r;

  // Accept when the sweep is done and the output slot frees up
  assign in_bus.ready  = !ram_busy && (!out_valid_r || out_bus.ready);
  assign acc           = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  bmm_pages u_pages (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_bus.valid),
    .cfg_data   (cfg_bus.rom_blocks),
    .acc_en     (acc),
    .op         (in_bus.op),
    .address    (in_bus.address),
    .write_data (in_bus.write_data),
    .dec        (dec)
  );

  bmm_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc && dec.ram_wr),
    .wr_idx  (in_bus.address[RAM_AW-1:0]),
    .wr_data (dec.wdata),
    .rd_en   (acc && dec.ram_rd),
    .rd_idx  (in_bus.address[RAM_AW-1:0]),
    .rd_data (ram_q),
    .busy    (ram_busy)
  );

  // Output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result fields of the accepted transaction
  always_ff @(posedge clk) begin
    if (acc) begin
      ram_sel_r     <= dec.ram_rd;
      rom_fetch_r   <= dec.rom_fetch;
      rom_address_r <= dec.rom_address;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.read_data   = ram_sel_r ? ram_q : '0;
  assign out_bus.rom_fetch   = rom_fetch_r;
  assign out_bus.rom_address = rom_address_r;

  // No transaction slips in during the RAM sweep
  a_no_acc_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    ram_busy |-> !in_bus.ready)
    else $error("transaction accepted during RAM clearing");

  // A write gives an all-zero result next cycle
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_bus.op == OP_WRITE)) |=>
      (out_valid_r && !ram_sel_r && !rom_fetch_r && (rom_address_r == '0)))
    else $error("write transaction produced a non-zero result");

  // A ROM fetch never carries RAM data
  a_fetch_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rom_fetch_r) |-> (out_bus.read_data == '0))
    else $error("ROM fetch result carries RAM data");

  // A RAM read never signals a ROM fetch
  a_ram_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && dec.ram_rd) |=> (!rom_fetch_r && (rom_address_r == '0)))
    else $error("RAM read flagged as ROM fetch");

endmodule

FILE: test/tb_banked_memory_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banked_memory_mapper
// Self-checking bench for the banked memory mapper. Bus accesses are driven
// through the input channel and mirrored in a local model of the work RAM,
// the three page slots and the ROM block count. Every result transaction is
// compared field by field with the oldest predicted result. The run covers
// directed corner accesses, several ROM block settings with random traffic,
// random idling on both channels and a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_banked_memory_mapper;
  import bmm_pkg::*;

  localparam logic [ADDR_W-1:0] REG_RAM_SELECT = 16'hFFFC;
  localparam logic [ADDR_W-1:0] WIN_LAST       = 16'hBFFF;
  localparam logic [ADDR_W-1:0] BUS_LAST       = 16'hFFFF;
  localparam int RANDOM_PER_PHASE = 245;
  localparam int QUIET_LIMIT      = 40000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int HOLD_OFF_CYCLES  = 300;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              rom_fetch;
    logic [ROM_AW-1:0] rom_address;
  } map_result_t;

  logic clk;
  logic rst_n;

  bmm_in_if  in_bus ();
  bmm_out_if out_bus ();
  bmm_cfg_if cfg_bus ();

  banked_memory_mapper uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Local copy of the mapper state
  logic [DATA_W-1:0] ram_shadow [RAM_BYTES];
  logic [DATA_W-1:0] slot_page [3];
  logic [DATA_W-1:0] blocks_cfg;

  map_result_t pending_results [$];
  int mismatches   = 0;
  int quiet_cycles = 0;
  int rx_hold_left = 0;
  bit tx_gaps_on   = 1'b0;
  bit rx_stalls_on = 1'b0;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mask a page value with the current ROM block count
  function automatic logic [DATA_W-1:0] masked_page(input logic [DATA_W-1:0] v,
                                                    input bit slot2);
    if (slot2 && (blocks_cfg <= PAGE_LO_MASK)) return v & blocks_cfg;
    return v & ((blocks_cfg & PAGE_HI_MASK) | PAGE_LO_MASK);
  endfunction

  // Apply one bus access to the local state and return its result
  function automatic map_result_t map_access(input op_t op,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [DATA_W-1:0] wdata);
    map_result_t r;
    logic [DATA_W-1:0] v;
    r = '0;
    v = wdata;
    if (op == OP_WRITE) begin
      if (addr >= RAM_BASE) begin
        case (addr)
          REG_SLOT0: begin
            v = masked_page(wdata, 1'b0);
            slot_page[0] = v;
          end
          REG_SLOT1: begin
            v = masked_page(wdata, 1'b0);
            slot_page[1] = v;
          end
          REG_SLOT2: begin
            v = masked_page(wdata, 1'b1);
            slot_page[2] = v;
          end
          default: ;
        endcase
        ram_shadow[addr[RAM_AW-1:0]] = v;
      end
    end else if (addr < RAM_BASE) begin
      r.rom_fetch = 1'b1;
      if (addr < FIXED_BYTES) begin
        r.rom_address = ROM_AW'(addr);
      end else begin
        r.rom_address = {slot_page[addr[ADDR_W-1:PAGE_AW]], addr[PAGE_AW-1:0]};
      end
    end else begin
      r.read_data = ram_shadow[addr[RAM_AW-1:0]];
    end
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one access and record its predicted result on acceptance
  task automatic send_access(input op_t op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.address    <= addr;
    in_bus.write_data <= wdata;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_results.push_back(map_access(op, addr, wdata));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the ROM block count; only called with the mapper idle
  task automatic write_rom_blocks(input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.rom_blocks <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    blocks_cfg = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One random access, or a page write followed by a read of its window
  task automatic send_random_access();
    int pick;
    int slot;
    logic [ADDR_W-1:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_access(OP_READ, ADDR_W'($urandom_range(0, FIXED_BYTES - 1)), 8'($urandom));
    end else if (pick < 35) begin
      send_access(OP_READ, ADDR_W'($urandom_range(FIXED_BYTES, WIN_LAST)), 8'($urandom));
    end else if (pick < 52) begin
      send_access(OP_WRITE, ADDR_W'($urandom_range(RAM_BASE, BUS_LAST)), 8'($urandom));
    end else if (pick < 70) begin
      send_access(OP_READ, ADDR_W'($urandom_range(RAM_BASE, BUS_LAST)), 8'($urandom));
    end else if (pick < 80) begin
      slot = $urandom_range(0, 2);
      base = (slot == 0) ? ADDR_W'(FIXED_BYTES) : ADDR_W'(slot * PAGE_BYTES);
      send_access(OP_WRITE, REG_SLOT0 + ADDR_W'(slot), 8'($urandom));
      send_access(OP_READ,
                  ADDR_W'($urandom_range(base, slot * PAGE_BYTES + PAGE_BYTES - 1)),
                  8'($urandom));
    end else if (pick < 90) begin
      send_access(op_t'($urandom_range(0, 1)),
                  REG_RAM_SELECT + ADDR_W'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      send_access(op_t'($urandom_range(0, 1)), ADDR_W'($urandom), 8'($urandom));
    end
  endtask

  // Reads of every region with the page slots at their reset values
  task automatic test_reset_map();
    send_access(OP_READ, 16'h0000, 8'hFF);
    send_access(OP_READ, 16'h03FF, 8'h00);
    send_access(OP_READ, 16'h0400, 8'h00);
    send_access(OP_READ, 16'h4000, 8'h00);
    send_access(OP_READ, 16'hBFFF, 8'h00);
    send_access(OP_READ, RAM_BASE, 8'h00);
  endtask

  // Ignored low writes, RAM and its mirror, the RAM select byte
  task automatic test_ram_mirror();
    send_access(OP_WRITE, 16'h0000, 8'h00);
    send_access(OP_WRITE, 16'hBFFF, 8'h55);
    send_access(OP_WRITE, RAM_BASE, 8'hFF);
    send_access(OP_WRITE, 16'hFFFB, 8'h01);
    send_access(OP_READ, 16'hE000, 8'h00);
    send_access(OP_READ, 16'hDFFB, 8'h00);
    send_access(OP_WRITE, REG_RAM_SELECT, 8'h80);
    send_access(OP_READ, REG_RAM_SELECT, 8'h00);
    send_access(OP_READ, 16'hDFFC, 8'h00);
  endtask

  // Page writes under the reset block count, then reads through the windows
  task automatic test_page_registers();
    send_access(OP_WRITE, REG_SLOT0, 8'hFF);
    send_access(OP_WRITE, REG_SLOT1, 8'hFF);
    send_access(OP_WRITE, REG_SLOT2, 8'hFF);
    send_access(OP_READ, REG_SLOT0, 8'h00);
    send_access(OP_READ, 16'h0400, 8'h00);
    send_access(OP_READ, 16'h4000, 8'h00);
    send_access(OP_READ, 16'h8000, 8'h00);
  endtask

  // Small ROM: the third slot takes the bare block count as its mask
  task automatic test_small_rom_slot2();
    wait_drain();
    write_rom_blocks(8'h05);
    send_access(OP_WRITE, REG_SLOT2, 8'hFF);
    send_access(OP_WRITE, REG_SLOT1, 8'hFF);
    send_access(OP_READ, 16'h8000, 8'h00);
    send_access(OP_READ, 16'h7FFF, 8'h00);
    wait_drain();
  endtask

  // Hold the result side off while accesses keep coming, so the input stalls
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_left = HOLD_OFF_CYCLES;
    repeat (40) send_random_access();
    wait_drain();
  endtask

  // Random traffic under one block count and one idling mode
  task automatic test_random_phase(input logic [DATA_W-1:0] blocks, input int mode);
    tx_gaps_on   = (mode == 1) || (mode >= 3);
    rx_stalls_on = (mode == 2) || (mode >= 3);
    write_rom_blocks(blocks);
    repeat (RANDOM_PER_PHASE) send_random_access();
    wait_drain();
  endtask

  // Result side readiness: hold-off, random stalls, or always ready
  initial begin
    int stall_left;
    int r;
    stall_left   = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_bus.ready <= 1'b0;
        rx_hold_left--;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (rx_stalls_on) begin
          r = $urandom_range(0, 99);
          if (r >= 95) stall_left = $urandom_range(10, 40);
          else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, read_data %0h rom_fetch %0b rom_address %0h",
                 $time, out_bus.read_data, out_bus.rom_fetch, out_bus.rom_address);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", 32'(want.read_data), 32'(out_bus.read_data));
        check_field("rom_fetch", 32'(want.rom_fetch), 32'(out_bus.rom_fetch));
        check_field("rom_address", 32'(want.rom_address), 32'(out_bus.rom_address));
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_banked_memory_mapper NOT OK");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [DATA_W-1:0] blocks_plan [7];
    blocks_plan = '{8'd0, 8'd255, 8'd15, 8'd16, 8'd7, 8'($urandom), 8'd32};
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.op          = OP_READ;
    in_bus.address     = '0;
    in_bus.write_data  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.rom_blocks = '0;
    foreach (ram_shadow[i]) ram_shadow[i] = '0;
    slot_page  = '{SLOT0_RST, SLOT1_RST, SLOT2_RST};
    blocks_cfg = ROM_BLOCKS_RST;

    // Hold reset, release on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_map();
    test_ram_mirror();
    test_page_registers();
    test_small_rom_slot2();
    test_backpressure();
    for (int p = 0; p < 7; p++) test_random_phase(blocks_plan[p], p);

    if (mismatches == 0) begin
      $display("tb_banked_memory_mapper OK");
    end else begin
      $display("tb_banked_memory_mapper NOT OK");
    end
    $finish;
  end

endmodule
